/* hdl/gzb_pkg.sv */
// ----------------------------------------------------------------------------
// gzb_pkg
// Shared constants for the non-integer bin detector: default widths,
// register indexes and the control word passed from resonator to output path.
// ----------------------------------------------------------------------------
package gzb_pkg;

  localparam int SAMPLE_W_DEF = 16;
  localparam int COEF_W_DEF   = 32;
  localparam int STATE_W_DEF  = 48;

  localparam int CFG_ADDR_W = 3;

  localparam logic [CFG_ADDR_W-1:0] REG_FB_COEF = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_A  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_B  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_C  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_D  = 3'd4;

  typedef struct packed {
    logic valid;
    logic ovf;
  } gzb_ctl_t;

endpackage

/* hdl/gzb_cfg.sv */
// ----------------------------------------------------------------------------
// gzb_cfg
// Coefficient register file, written by index, reset to zero.
// ----------------------------------------------------------------------------
module gzb_cfg import gzb_pkg::*; #(
  parameter int COEF_WIDTH = COEF_W_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wen,
  input  logic [CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [COEF_WIDTH-1:0]        cfg_wdata,
  output logic signed [COEF_WIDTH-1:0] fb_coef,
  output logic signed [COEF_WIDTH-1:0] coef_a,
  output logic signed [COEF_WIDTH-1:0] coef_b,
  output logic signed [COEF_WIDTH-1:0] coef_c,
  output logic signed [COEF_WIDTH-1:0] coef_d
);

  logic [COEF_WIDTH-1:0] tca_r, a_r, b_r, c_r, d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tca_r <= '0;
      a_r   <= '0;
      b_r   <= '0;
      c_r   <= '0;
      d_r   <= '0;
    end else if (cfg_wen) begin
      case (cfg_addr)
        REG_FB_COEF: tca_r <= cfg_wdata;
        REG_COEF_A:  a_r   <= cfg_wdata;
        REG_COEF_B:  b_r   <= cfg_wdata;
        REG_COEF_C:  c_r   <= cfg_wdata;
        REG_COEF_D:  d_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign fb_coef = $signed(tca_r);
  assign coef_a  = $signed(a_r);
  assign coef_b  = $signed(b_r);
  assign coef_c  = $signed(c_r);
  assign coef_d  = $signed(d_r);

endmodule

/* hdl/gzb_resonator.sv */
// ----------------------------------------------------------------------------
// gzb_resonator
// Input register and second-order resonator w0 = x + 2cos(alpha)*w1 - w2,
// one update per cycle when not stalled; saturation, sticky overflow flag.
// ----------------------------------------------------------------------------
module gzb_resonator import gzb_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_W_DEF,
  parameter int COEF_WIDTH   = COEF_W_DEF,
  parameter int STATE_WIDTH  = STATE_W_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [SAMPLE_WIDTH-1:0]      in_sample,
  input  logic                         in_last,
  input  logic signed [COEF_WIDTH-1:0] fb_coef,
  output gzb_ctl_t                     res_ctl,
  input  logic                         res_ready,
  output logic [STATE_WIDTH-1:0]       res_w1,
  output logic [STATE_WIDTH-1:0]       res_w2
);

  localparam int H    = STATE_WIDTH / 2;
  localparam int HI_W = STATE_WIDTH - H;
  localparam int PW   = STATE_WIDTH + COEF_WIDTH;
  localparam int SW4  = STATE_WIDTH + 4;
  localparam logic [PW:0] HALF = {{(PW + 3 - COEF_WIDTH){1'b0}}, 1'b1,
                                  {(COEF_WIDTH - 3){1'b0}}};
  localparam logic [STATE_WIDTH-1:0] SAT_MAX = {1'b0, {(STATE_WIDTH - 1){1'b1}}};
  localparam logic [STATE_WIDTH-1:0] SAT_MIN = {1'b1, {(STATE_WIDTH - 1){1'b0}}};

  logic                    s0_valid_r;
  logic [SAMPLE_WIDTH-1:0] s0_sample_r;
  logic                    s0_last_r;
  logic [STATE_WIDTH-1:0]  w1_r, w2_r;
  logic                    sat_r;

  logic                         s0_adv;
  logic signed [H+COEF_WIDTH:0] pp_lo;
  logic signed [PW-H-1:0]       pp_hi;
  logic [PW-1:0]                prod;
  logic [PW:0]                  prod_rnd;
  logic [SW4-1:0]               acc;
  logic                         fits;
  logic [STATE_WIDTH-1:0]       w0;
  logic                         sat_now;

  function automatic logic [PW-1:0] join_pp(logic [H+COEF_WIDTH:0] lo,
                                            logic [PW-H-1:0] hi);
    return {hi, {H{1'b0}}} + {{(HI_W - 1){lo[H+COEF_WIDTH]}}, lo};
  endfunction

  assign s0_adv    = s0_valid_r && (!s0_last_r || res_ready);
  assign in_tready = !s0_valid_r || s0_adv;

  always_comb begin
    pp_lo    = $signed({1'b0, w1_r[H-1:0]}) * fb_coef;
    pp_hi    = $signed(w1_r[STATE_WIDTH-1:H]) * fb_coef;
    prod     = join_pp(pp_lo, pp_hi);
    prod_rnd = {prod[PW-1], prod} + HALF;
    acc      = {prod_rnd[PW], prod_rnd[PW:COEF_WIDTH-2]}
             + {{(SW4 - SAMPLE_WIDTH){s0_sample_r[SAMPLE_WIDTH-1]}}, s0_sample_r}
             - {{4{w2_r[STATE_WIDTH-1]}}, w2_r};
    fits     = (acc[SW4-1:STATE_WIDTH-1] == {5{acc[STATE_WIDTH-1]}});
    sat_now  = !fits;
    if (fits) begin
      w0 = acc[STATE_WIDTH-1:0];
    end else if (acc[SW4-1]) begin
      w0 = SAT_MIN;
    end else begin
      w0 = SAT_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
      w1_r       <= '0;
      w2_r       <= '0;
      sat_r      <= 1'b0;
    end else begin
      if (in_tready) begin
        s0_valid_r <= in_tvalid;
      end
      if (s0_adv) begin
        if (s0_last_r) begin
          w1_r  <= '0;
          w2_r  <= '0;
          sat_r <= 1'b0;
        end else begin
          w1_r  <= w0;
          w2_r  <= w1_r;
          sat_r <= sat_r | sat_now;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s0_sample_r <= in_sample;
      s0_last_r   <= in_last;
    end
  end

  assign res_ctl.valid = s0_valid_r && s0_last_r;
  assign res_ctl.ovf   = sat_r | sat_now;
  assign res_w1        = w0;
  assign res_w2        = w1_r;

`ifndef SYNTHESIS
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (s0_adv && s0_last_r) |=> (w1_r == '0 && w2_r == '0 && !sat_r))
    else $error("resonator state not cleared after last sample");

  a_sat_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (sat_r && !(s0_adv && s0_last_r)) |=> sat_r)
    else $error("saturation flag dropped inside a block");
`endif

endmodule

/* hdl/gzb_outcalc.sv */
// ----------------------------------------------------------------------------
// gzb_outcalc
// Output path: partial products, exact sums, rounding and saturation of the
// real and imaginary parts, ending in the result register.
// ----------------------------------------------------------------------------
module gzb_outcalc import gzb_pkg::*; #(
  parameter int COEF_WIDTH  = COEF_W_DEF,
  parameter int STATE_WIDTH = STATE_W_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic signed [COEF_WIDTH-1:0] coef_a,
  input  logic signed [COEF_WIDTH-1:0] coef_b,
  input  logic signed [COEF_WIDTH-1:0] coef_c,
  input  logic signed [COEF_WIDTH-1:0] coef_d,
  input  gzb_ctl_t                     res_ctl,
  output logic                         res_ready,
  input  logic [STATE_WIDTH-1:0]       res_w1,
  input  logic [STATE_WIDTH-1:0]       res_w2,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [STATE_WIDTH-1:0]       out_real,
  output logic [STATE_WIDTH-1:0]       out_imag,
  output logic                         out_ovf
);

  localparam int H    = STATE_WIDTH / 2;
  localparam int HI_W = STATE_WIDTH - H;
  localparam int PW   = STATE_WIDTH + COEF_WIDTH;
  localparam int LO_W = H + COEF_WIDTH + 1;
  localparam int HP_W = HI_W + COEF_WIDTH;
  localparam int SW4  = STATE_WIDTH + 4;
  localparam logic [PW+1:0] HALF = {{(PW + 4 - COEF_WIDTH){1'b0}}, 1'b1,
                                    {(COEF_WIDTH - 3){1'b0}}};
  localparam logic [STATE_WIDTH-1:0] SAT_MAX = {1'b0, {(STATE_WIDTH - 1){1'b1}}};
  localparam logic [STATE_WIDTH-1:0] SAT_MIN = {1'b1, {(STATE_WIDTH - 1){1'b0}}};

  logic                   p1_valid_r, p1_ovf_r;
  logic [STATE_WIDTH-1:0] p1_w1_r, p1_w2_r;
  logic                   p2_valid_r, p2_ovf_r;
  logic [LO_W-1:0]        p2_lo_r [4];
  logic [HP_W-1:0]        p2_hi_r [4];
  logic                   p3_valid_r, p3_ovf_r;
  logic [PW:0]            p3_re_r, p3_im_r;
  logic                   out_valid_r, out_ovf_r;
  logic [STATE_WIDTH-1:0] out_re_r, out_im_r;

  logic                   out_free, p3_ready, p2_ready, p1_ready;
  logic [LO_W-1:0]        lo_nxt [4];
  logic [HP_W-1:0]        hi_nxt [4];
  logic [STATE_WIDTH-1:0] opw [4];
  logic signed [COEF_WIDTH-1:0] opc [4];
  logic [PW-1:0]          full [4];
  logic [PW:0]            re_nxt, im_nxt;
  logic [PW+1:0]          re_rnd, im_rnd;
  logic [SW4-1:0]         re_sh, im_sh;
  logic                   re_fits, im_fits;
  logic [STATE_WIDTH-1:0] re_sat, im_sat;

  function automatic logic [PW-1:0] join_pp(logic [LO_W-1:0] lo, logic [HP_W-1:0] hi);
    return {hi, {H{1'b0}}} + {{(HI_W - 1){lo[LO_W-1]}}, lo};
  endfunction

  function automatic logic [STATE_WIDTH-1:0] sat_part(logic [SW4-1:0] v, logic ok);
    if (ok) begin
      return v[STATE_WIDTH-1:0];
    end else if (v[SW4-1]) begin
      return SAT_MIN;
    end else begin
      return SAT_MAX;
    end
  endfunction

  assign out_free  = !out_valid_r || out_tready;
  assign p3_ready  = !p3_valid_r || out_free;
  assign p2_ready  = !p2_valid_r || p3_ready;
  assign p1_ready  = !p1_valid_r || p2_ready;
  assign res_ready = p1_ready;

  // products in order: w1*a, w2*c, w1*b, w2*d
  always_comb begin
    opw[0] = p1_w1_r;
    opw[1] = p1_w2_r;
    opw[2] = p1_w1_r;
    opw[3] = p1_w2_r;
    opc[0] = coef_a;
    opc[1] = coef_c;
    opc[2] = coef_b;
    opc[3] = coef_d;
    for (int k = 0; k < 4; k++) begin
      lo_nxt[k] = $signed({1'b0, opw[k][H-1:0]}) * opc[k];
      hi_nxt[k] = $signed(opw[k][STATE_WIDTH-1:H]) * opc[k];
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      full[k] = join_pp(p2_lo_r[k], p2_hi_r[k]);
    end
    re_nxt = {full[0][PW-1], full[0]} + {full[1][PW-1], full[1]};
    im_nxt = {full[2][PW-1], full[2]} + {full[3][PW-1], full[3]};
  end

  always_comb begin
    re_rnd  = {p3_re_r[PW], p3_re_r} + HALF;
    im_rnd  = {p3_im_r[PW], p3_im_r} + HALF;
    re_sh   = re_rnd[PW+1:COEF_WIDTH-2];
    im_sh   = im_rnd[PW+1:COEF_WIDTH-2];
    re_fits = (re_sh[SW4-1:STATE_WIDTH-1] == {5{re_sh[STATE_WIDTH-1]}});
    im_fits = (im_sh[SW4-1:STATE_WIDTH-1] == {5{im_sh[STATE_WIDTH-1]}});
    re_sat  = sat_part(re_sh, re_fits);
    im_sat  = sat_part(im_sh, im_fits);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r  <= 1'b0;
      p2_valid_r  <= 1'b0;
      p3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (p1_ready) begin
        p1_valid_r <= res_ctl.valid;
      end
      if (p2_ready) begin
        p2_valid_r <= p1_valid_r;
      end
      if (p3_ready) begin
        p3_valid_r <= p2_valid_r;
      end
      if (out_free) begin
        out_valid_r <= p3_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (p1_ready && res_ctl.valid) begin
      p1_w1_r  <= res_w1;
      p1_w2_r  <= res_w2;
      p1_ovf_r <= res_ctl.ovf;
    end
    if (p2_ready && p1_valid_r) begin
      p2_lo_r  <= lo_nxt;
      p2_hi_r  <= hi_nxt;
      p2_ovf_r <= p1_ovf_r;
    end
    if (p3_ready && p2_valid_r) begin
      p3_re_r  <= re_nxt;
      p3_im_r  <= im_nxt;
      p3_ovf_r <= p2_ovf_r;
    end
    if (out_free && p3_valid_r) begin
      out_re_r  <= re_sat;
      out_im_r  <= im_sat;
      out_ovf_r <= p3_ovf_r | !re_fits | !im_fits;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_real   = out_re_r;
  assign out_imag   = out_im_r;
  assign out_ovf    = out_ovf_r;

`ifndef SYNTHESIS
  a_result_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(p3_valid_r))
    else $error("result appeared without a word in the last stage");

  a_capture: assert property (@(posedge clk) disable iff (!rst_n)
    (res_ctl.valid && res_ready) |=> p1_valid_r)
    else $error("end-of-block state not captured");

  a_stall_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (p3_valid_r && out_valid_r && !out_tready) |=> (p3_valid_r && out_valid_r))
    else $error("word lost while output stalled");
`endif

endmodule

/* hdl/goertzel_noninteger_bin.sv */
// ----------------------------------------------------------------------------
// goertzel_noninteger_bin
// Single-bin detector for a non-integer frequency index.
// ----------------------------------------------------------------------------
// in channel: one signed sample per word on in_tdata, in_tlast marks the
//   last sample of a block. One word is taken every cycle while in_tready is
//   high; the resonator multiply-add is combinational, closing its loop.
// out channel: one word per block, real part and imaginary part on
//   out_tdata, out_tuser set if any saturation happened in that block.
// result: the end-of-block state moves from the input register through p1,
//   p2, p3 and the output register; the output path is a four-register
//   pipeline after the input register.
// stall: a waiting result holds in the output register; samples keep flowing
//   until a last sample finds the output pipeline full, then in_tready drops.
// cfg: write the five coefficients (signed Q2.30) by index while idle.
// reset: coefficients, resonator state and the overflow flag go to zero,
//   all pipeline stages empty.
// ----------------------------------------------------------------------------
module goertzel_noninteger_bin import gzb_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_W_DEF,
  parameter int COEF_WIDTH   = COEF_W_DEF,
  parameter int STATE_WIDTH  = STATE_W_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  input  logic [((SAMPLE_WIDTH + 7) / 8) * 8-1:0] in_tdata,    // sample
  input  logic                                    in_tlast,    // last_sample
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  output logic [((2 * STATE_WIDTH + 7) / 8) * 8-1:0] out_tdata, // real_part, imag_part
  output logic                                    out_tuser,   // overflowed
  input  logic                                    cfg_wen,
  input  logic [CFG_ADDR_W-1:0]                   cfg_addr,
  input  logic [COEF_WIDTH-1:0]                   cfg_wdata
);

  localparam int OUT_W = ((2 * STATE_WIDTH + 7) / 8) * 8;

  logic signed [COEF_WIDTH-1:0] fb_coef, coef_a, coef_b, coef_c, coef_d;
  gzb_ctl_t                     res_ctl;
  logic                         res_ready;
  logic [STATE_WIDTH-1:0]       res_w1, res_w2;
  logic [STATE_WIDTH-1:0]       out_real, out_imag;

  gzb_cfg #(
    .COEF_WIDTH(COEF_WIDTH)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wen  (cfg_wen),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .fb_coef  (fb_coef),
    .coef_a   (coef_a),
    .coef_b   (coef_b),
    .coef_c   (coef_c),
    .coef_d   (coef_d)
  );

  gzb_resonator #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .COEF_WIDTH  (COEF_WIDTH),
    .STATE_WIDTH (STATE_WIDTH)
  ) u_resonator (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_sample(in_tdata[SAMPLE_WIDTH-1:0]),
    .in_last  (in_tlast),
    .fb_coef  (fb_coef),
    .res_ctl  (res_ctl),
    .res_ready(res_ready),
    .res_w1   (res_w1),
    .res_w2   (res_w2)
  );

  gzb_outcalc #(
    .COEF_WIDTH (COEF_WIDTH),
    .STATE_WIDTH(STATE_WIDTH)
  ) u_outcalc (
    .clk       (clk),
    .rst_n     (rst_n),
    .coef_a    (coef_a),
    .coef_b    (coef_b),
    .coef_c    (coef_c),
    .coef_d    (coef_d),
    .res_ctl   (res_ctl),
    .res_ready (res_ready),
    .res_w1    (res_w1),
    .res_w2    (res_w2),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_real  (out_real),
    .out_imag  (out_imag),
    .out_ovf   (out_tuser)
  );

  assign out_tdata = OUT_W'({out_imag, out_real});

endmodule
